@@ rtl/dkd_pkg.sv @@
// Shared types and constants for the double knock detector.
// Holds the configuration register layout, register indexes and reset values.
// No dependencies.
package dkd_pkg;

  localparam int THRESH_W   = 10;
  localparam int MS_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 2'd3;

  localparam logic [THRESH_W-1:0] THRESHOLD_RST = 10'd512;
  localparam logic [MS_W-1:0]     DEBOUNCE_RST  = 16'd50;
  localparam logic [MS_W-1:0]     MIN_GAP_RST   = 16'd100;
  localparam logic [MS_W-1:0]     MAX_GAP_RST   = 16'd600;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [MS_W-1:0]     debounce_ms;
    logic [MS_W-1:0]     min_gap_ms;
    logic [MS_W-1:0]     max_gap_ms;
  } cfg_t;

endpackage

@@ rtl/dkd_cfg_regs.sv @@
// Configuration register file of the double knock detector.
// Depends on dkd_pkg for the register layout, indexes and reset values.
module dkd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dkd_pkg::CFG_DATA_W-1:0] cfg_data,
  output dkd_pkg::cfg_t                  cfg
);
  import dkd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: cfg_nxt.threshold   = cfg_data[THRESH_W-1:0];
        REG_DEBOUNCE:  cfg_nxt.debounce_ms = cfg_data[MS_W-1:0];
        REG_MIN_GAP:   cfg_nxt.min_gap_ms  = cfg_data[MS_W-1:0];
        REG_MAX_GAP:   cfg_nxt.max_gap_ms  = cfg_data[MS_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold   <= THRESHOLD_RST;
      cfg_r.debounce_ms <= DEBOUNCE_RST;
      cfg_r.min_gap_ms  <= MIN_GAP_RST;
      cfg_r.max_gap_ms  <= MAX_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/dkd_core.sv @@
// Knock detection state and per-sample decision logic.
// Depends on dkd_pkg for the configuration struct.
module dkd_core #(
  parameter int SAMPLE_BITS = 10,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] smp,
  input  logic [TIME_BITS-1:0]   now,
  input  dkd_pkg::cfg_t          cfg,
  output logic                   dbl,
  output logic                   sw_on
);
  import dkd_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  logic [SAMPLE_BITS-1:0] prev_r;
  logic                   wait_r;
  logic                   wait_nxt;
  logic [TIME_BITS-1:0]   first_r;
  logic [TIME_BITS-1:0]   first_nxt;
  logic [TIME_BITS-1:0]   last_r;
  logic [TIME_BITS-1:0]   last_nxt;
  logic                   toggle_r;
  logic                   toggle_nxt;

  logic [CMP_W-1:0]     smp_x;
  logic [CMP_W-1:0]     prev_x;
  logic [CMP_W-1:0]     thr_x;
  logic [TIME_BITS-1:0] since_last;
  logic [TIME_BITS-1:0] gap;
  logic [TIME_BITS-1:0] deb_x;
  logic [TIME_BITS-1:0] min_x;
  logic [TIME_BITS-1:0] max_x;
  logic                 rising;
  logic                 trig;
  logic                 dbl_c;

  always_comb begin
    smp_x      = CMP_W'(smp);
    prev_x     = CMP_W'(prev_r);
    thr_x      = CMP_W'(cfg.threshold);
    deb_x      = TIME_BITS'(cfg.debounce_ms);
    min_x      = TIME_BITS'(cfg.min_gap_ms);
    max_x      = TIME_BITS'(cfg.max_gap_ms);
    since_last = now - last_r;
    gap        = now - first_r;
    rising     = (smp_x > thr_x) && (prev_x <= thr_x);
    trig       = rising && (since_last >= deb_x);
    dbl_c      = trig && wait_r && (gap >= min_x) && (gap <= max_x);

    wait_nxt   = wait_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    toggle_nxt = toggle_r ^ dbl_c;
    if (trig) begin
      last_nxt = now;
      if (!wait_r) begin
        first_nxt = now;
        wait_nxt  = 1'b1;
      end else begin
        wait_nxt = 1'b0;
      end
    end
    // A fresh first knock has a zero gap, so the timeout only applies when
    // the wait was already running and no knock was counted this sample.
    if (wait_r && !trig && (gap > max_x)) begin
      wait_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      wait_r   <= 1'b0;
      first_r  <= '0;
      last_r   <= '0;
      toggle_r <= 1'b0;
    end else if (step) begin
      prev_r   <= smp;
      wait_r   <= wait_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      toggle_r <= toggle_nxt;
    end
  end

  assign dbl   = dbl_c;
  assign sw_on = toggle_nxt;

  a_dbl_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    (step && dbl_c) |=> (toggle_r != $past(toggle_r)))
    else $error("double knock did not toggle the switch");

  a_no_dbl_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !dbl_c) |=> $stable(toggle_r))
    else $error("switch changed without a double knock");

  a_dbl_needs_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dbl_c |-> (wait_r && trig))
    else $error("double knock flagged outside a counted second knock");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(wait_r) && $stable(last_r) && $stable(prev_r)))
    else $error("detector state moved without a sample");

endmodule

@@ rtl/double_knock_detector_unit.sv @@
// Top level of the double knock detector: input register, detector core,
// result register. Depends on dkd_pkg, dkd_cfg_regs and dkd_core.
//
// Each accepted sample beat produces exactly one result beat, passing
// through the input register and then the result register; one sample per
// clock is sustained while the result side is ready. The whole decision for
// a sample (threshold crossing, debounce, gap window, timeout and switch
// toggle) is made combinationally between the input register and the
// result register, where the detector state is updated, and a full result
// register still lets the input register take a new beat as soon as its
// own beat moves on. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user writes it only while no beat is in flight, which the block does not enforce.
module double_knock_detector_unit #(
  parameter int SAMPLE_BITS = 10,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_BITS-1:0]         in_sample,
  input  logic [TIME_BITS-1:0]           in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_double_knock,
  output logic                           out_switch_on,
  input  logic                           cfg_we,
  input  logic [dkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dkd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dkd_pkg::*;

  cfg_t cfg;

  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [TIME_BITS-1:0]   s1_now_r;
  logic                   out_valid_r;
  logic                   out_dbl_r;
  logic                   out_sw_r;
  logic                   adv;
  logic                   step;
  logic                   dbl;
  logic                   sw_on;

  dkd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dkd_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .smp   (s1_sample_r),
    .now   (s1_now_r),
    .cfg   (cfg),
    .dbl   (dbl),
    .sw_on (sw_on)
  );

  // The result register can take a beat when empty or being drained.
  assign adv      = !out_valid_r || out_ready;
  assign step     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
      s1_now_r    <= in_now_ms;
    end
    if (step) begin
      out_dbl_r <= dbl;
      out_sw_r  <= sw_on;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_double_knock = out_dbl_r;
  assign out_switch_on    = out_sw_r;

endmodule

@@ test/double_knock_detector_unit_tb.sv @@
// Self-checking testbench for double_knock_detector_unit: a directed table, then random
// knock sequences under several register settings, checked against an in-bench predictor.
// Depends on dkd_pkg and the double_knock_detector_unit RTL.
`timescale 1ns / 100ps

module double_knock_detector_unit_tb;
  import dkd_pkg::*;

  localparam int SMP_W  = 10;
  localparam int TIME_W = 32;

  typedef struct packed {
    logic dbl;
    logic sw;
  } knock_result_t;

  typedef struct packed {
    logic [SMP_W-1:0]  level;
    logic [TIME_W-1:0] stamp;
    logic              typed;
    logic              dbl;
    logic              sw;
  } knock_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_QUARTER, RX_SPARSE} rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SMP_W-1:0]      in_sample = '0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  out_double_knock;
  logic                  out_switch_on;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Typed expectation travelling with the beat on the input channel.
  logic row_typed = 1'b0;
  logic row_dbl = 1'b0;
  logic row_sw = 1'b0;

  // Predictor copy of the registers and the detector state.
  cfg_t              model_cfg = '{THRESHOLD_RST, DEBOUNCE_RST, MIN_GAP_RST, MAX_GAP_RST};
  logic [SMP_W-1:0]  prev_level = '0;
  logic              armed = 1'b0;
  logic [TIME_W-1:0] first_knock_ms = '0;
  logic [TIME_W-1:0] last_knock_ms = '0;
  logic              switch_state = 1'b0;

  knock_result_t     pending_results[$];
  int                error_count = 0;
  int                burst_left = 0;
  logic [TIME_W-1:0] last_loud_ms = '0;
  rx_mode_e          rx_mode = RX_FREE;
  logic [7:0]        pace_cnt = '0;

  // Directed table, run with the reset register values.
  knock_row_t probe_rows [0:24] = '{
    '{10'd0,    32'd0,          1'b1, 1'b0, 1'b0},
    '{10'd1023, 32'd10,         1'b1, 1'b0, 1'b0},  // too soon after time zero
    '{10'd0,    32'd20,         1'b1, 1'b0, 1'b0},
    '{10'd1023, 32'd100,        1'b0, 1'b0, 1'b0},
    '{10'd512,  32'd150,        1'b0, 1'b0, 1'b0},
    '{10'd513,  32'd300,        1'b0, 1'b0, 1'b0},
    '{10'd0,    32'd400,        1'b0, 1'b0, 1'b0},
    '{10'd600,  32'd420,        1'b0, 1'b0, 1'b0},
    '{10'd0,    32'd1100,       1'b0, 1'b0, 1'b0},
    '{10'd700,  32'd1110,       1'b0, 1'b0, 1'b0},
    '{10'd0,    32'd1160,       1'b0, 1'b0, 1'b0},
    '{10'd700,  32'd1170,       1'b0, 1'b0, 1'b0},
    '{10'd0,    32'd1300,       1'b0, 1'b0, 1'b0},
    '{10'd1000, 32'd1330,       1'b0, 1'b0, 1'b0},
    '{10'd0,    32'd1340,       1'b0, 1'b0, 1'b0},
    '{10'd1000, 32'd1360,       1'b0, 1'b0, 1'b0},
    '{10'd0,    32'd1400,       1'b0, 1'b0, 1'b0},
    '{10'd1000, 32'd1930,       1'b0, 1'b0, 1'b0},
    '{10'd0,    32'd2000,       1'b0, 1'b0, 1'b0},
    '{10'd1023, 32'hFFFF_FFF0,  1'b0, 1'b0, 1'b0},
    '{10'd0,    32'hFFFF_FFF8,  1'b0, 1'b0, 1'b0},
    '{10'd1023, 32'h0000_0060,  1'b0, 1'b0, 1'b0},
    '{10'd0,    32'h0000_0050,  1'b0, 1'b0, 1'b0},
    '{10'd1023, 32'h0000_0040,  1'b0, 1'b0, 1'b0},
    '{10'd0,    32'h0000_0030,  1'b0, 1'b0, 1'b0}
  };

  double_knock_detector_unit #(
    .SAMPLE_BITS(SMP_W),
    .TIME_BITS  (TIME_W)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_double_knock(out_double_knock),
    .out_switch_on   (out_switch_on),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("%0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic knock_result_t predict_knock(input logic [SMP_W-1:0] smp,
                                                  input logic [TIME_W-1:0] now);
    knock_result_t     res;
    logic              rising;
    logic [TIME_W-1:0] since_last;
    logic [TIME_W-1:0] gap;
    res.dbl = 1'b0;
    rising = (smp > model_cfg.threshold) && (prev_level <= model_cfg.threshold);
    since_last = now - last_knock_ms;
    if (rising && since_last >= TIME_W'(model_cfg.debounce_ms)) begin
      if (!armed) begin
        first_knock_ms = now;
        armed = 1'b1;
      end else begin
        gap = now - first_knock_ms;
        if (gap >= TIME_W'(model_cfg.min_gap_ms) && gap <= TIME_W'(model_cfg.max_gap_ms)) begin
          res.dbl = 1'b1;
          switch_state = ~switch_state;
        end
        armed = 1'b0;
      end
      last_knock_ms = now;
    end
    // The timeout looks at the first knock time as updated above.
    gap = now - first_knock_ms;
    if (armed && gap > TIME_W'(model_cfg.max_gap_ms)) armed = 1'b0;
    prev_level = smp;
    res.sw = switch_state;
    return res;
  endfunction

  always @(posedge clk) begin : beat_monitor
    knock_result_t predicted;
    knock_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = predict_knock(in_sample, in_now_ms);
        if (row_typed) begin
          predicted.dbl = row_dbl;
          predicted.sw = row_sw;
        end
        pending_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with no sample waiting for it");
        end else begin
          want = pending_results.pop_front();
          if (out_double_knock !== want.dbl)
            report_mismatch($sformatf("double_knock expected %0b got %0b",
                                      want.dbl, out_double_knock));
          if (out_switch_on !== want.sw)
            report_mismatch($sformatf("switch_on expected %0b got %0b",
                                      want.sw, out_switch_on));
        end
      end
    end
  end

  // The result side stalls on its own pattern, redrawn when pace_cnt[5:0] is zero.
  always @(negedge clk) begin
    pace_cnt++;
    if (pace_cnt[5:0] == 6'd0) rx_mode = rx_mode_e'($urandom_range(3));
    case (rx_mode)
      RX_FREE:    out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= ($urandom_range(3) != 0);
      RX_QUARTER: out_ready <= (pace_cnt[1:0] == 2'd0);
      default:    out_ready <= (pace_cnt[2:0] == 3'd0);
    endcase
  end

  task automatic send_item(input logic [SMP_W-1:0] smp, input logic [TIME_W-1:0] now,
                           input logic typed, input logic exp_dbl, input logic exp_sw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= smp;
    in_now_ms <= now;
    row_typed <= typed;
    row_dbl <= exp_dbl;
    row_sw <= exp_sw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_THRESHOLD: model_cfg.threshold = data[THRESH_W-1:0];
      REG_DEBOUNCE:  model_cfg.debounce_ms = data;
      REG_MIN_GAP:   model_cfg.min_gap_ms = data;
      default:       model_cfg.max_gap_ms = data;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [THRESH_W-1:0] thr, input logic [MS_W-1:0] db,
                               input logic [MS_W-1:0] mn, input logic [MS_W-1:0] mx);
    wait_idle();
    // The unused upper bits of the threshold write carry junk on purpose.
    write_reg(REG_THRESHOLD, {6'($urandom_range(63)), thr});
    write_reg(REG_DEBOUNCE, db);
    write_reg(REG_MIN_GAP, mn);
    write_reg(REG_MAX_GAP, mx);
  endtask

  function automatic logic [SMP_W-1:0] quiet_level();
    if ($urandom_range(2) == 0) return model_cfg.threshold;
    return SMP_W'($urandom_range(model_cfg.threshold));
  endfunction

  function automatic logic [SMP_W-1:0] loud_level();
    if (model_cfg.threshold == 10'd1023) return 10'd1023;
    if ($urandom_range(2) == 0) return model_cfg.threshold + 10'd1;
    return SMP_W'($urandom_range(model_cfg.threshold + 1, 1023));
  endfunction

  // Spacing between loud samples, mostly close to one of the timing bounds.
  function automatic logic [TIME_W-1:0] knock_gap();
    logic [TIME_W-1:0] base;
    case ($urandom_range(4))
      0:       base = TIME_W'(model_cfg.debounce_ms);
      1:       base = TIME_W'(model_cfg.min_gap_ms);
      2:       base = TIME_W'(model_cfg.max_gap_ms);
      3:       base = TIME_W'(model_cfg.max_gap_ms) + 1;
      default: base = $urandom_range(0, 2 * model_cfg.max_gap_ms + 2);
    endcase
    return base + $urandom_range(0, 4) - 2;
  endfunction

  task automatic run_knocks(input int n_items);
    int                sent;
    logic [TIME_W-1:0] g;
    logic [TIME_W-1:0] stamp;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        // Noise: any level at any time, which also walks the clock across the wrap.
        stamp = $urandom();
        send_item(SMP_W'($urandom_range(1023)), stamp, 1'b0, 1'b0, 1'b0);
        if ($urandom_range(1) == 0) last_loud_ms = stamp;
        sent++;
      end else begin
        g = knock_gap();
        repeat ($urandom_range(1, 2)) begin
          stamp = ($urandom_range(1) == 0) ? last_loud_ms + g / 2
                                           : last_loud_ms + g - $urandom_range(0, 1);
          send_item(quiet_level(), stamp, 1'b0, 1'b0, 1'b0);
          sent++;
        end
        last_loud_ms = last_loud_ms + g;
        send_item(loud_level(), last_loud_ms, 1'b0, 1'b0, 1'b0);
        sent++;
        // A held loud level is not a new knock.
        if ($urandom_range(9) == 0) begin
          send_item(loud_level(), last_loud_ms + $urandom_range(0, 3), 1'b0, 1'b0, 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i])
      send_item(probe_rows[i].level, probe_rows[i].stamp, probe_rows[i].typed,
                probe_rows[i].dbl, probe_rows[i].sw);
    last_loud_ms = 32'd3000;
    run_knocks(120);

    apply_setting(10'd0, 16'd0, 16'd0, 16'd0);
    run_knocks(100);
    apply_setting(10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_knocks(60);
    // Window reversed: second knocks only drop back to idle.
    apply_setting(10'd300, 16'd20, 16'd500, 16'd200);
    run_knocks(100);
    apply_setting(10'd1022, 16'd0, 16'd0, 16'hFFFF);
    run_knocks(80);
    apply_setting(10'd511, 16'd10, 16'd30, 16'd90);
    run_knocks(120);
    repeat (2) begin
      apply_setting(THRESH_W'($urandom_range(1023)), MS_W'($urandom_range(200)),
                    MS_W'($urandom_range(1000)), MS_W'($urandom_range(2000)));
      run_knocks(100);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
